@@ src/itf_pkg.sv @@
package itf_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int MAX_PAD_DEF     = 62;
    localparam int VALUE_PORT_W    = 64;
    localparam int PAD_W           = 6;
    localparam int CHAR_W          = 8;
    localparam int HEX_RADIX       = 16;
    localparam int DIGIT_W         = $clog2(HEX_RADIX);

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

    localparam logic [DIGIT_W-1:0] DEC_RADIX = 4'd10;
    // shift-and-add-3 correction for binary to BCD
    localparam logic [DIGIT_W-1:0] DD_THRESH = 4'd5;
    localparam logic [DIGIT_W-1:0] DD_ADJ    = 4'd3;

    typedef struct packed {
        logic             negative;
        logic             upper;
        logic             zero_pad;
        logic [PAD_W-1:0] pad;
    } fmt_t;

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] digit;
    } conv_stat_t;

    // digit slots needed for the larger of decimal and hex renderings
    function automatic int ndigits(input int vw);
        int dec_n;
        int hex_n;
        dec_n = (vw * 78) / 256 + 1;
        hex_n = (vw + 3) / 4;
        return (dec_n > hex_n) ? dec_n : hex_n;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [DIGIT_W-1:0] off;
        off = d - DEC_RADIX;
        if (d < DEC_RADIX) begin
            return CHAR_ZERO + CHAR_W'(d);
        end
        return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(off);
    endfunction

endpackage

@@ src/itf_conv.sv @@
module itf_conv #(
    parameter int VALUE_WIDTH = itf_pkg::VALUE_WIDTH_DEF,
    localparam int NDIG = itf_pkg::ndigits(VALUE_WIDTH),
    localparam int NDW  = $clog2(NDIG + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic                   hex,
    input  logic [VALUE_WIDTH-1:0] mag,
    input  logic                   pop,
    output itf_pkg::conv_stat_t    stat,
    output logic [NDW-1:0]         ndig
);
    import itf_pkg::*;

    localparam int BW    = $clog2(VALUE_WIDTH + 1);
    localparam int BCD_W = NDIG * DIGIT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_STRIP = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic                   hex_reg, hex_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BW-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [NDW-1:0]         dig_cnt_reg, dig_cnt_next;
    logic [BCD_W-1:0]       adj;
    logic [DIGIT_W-1:0]     top_digit;

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];

    // per-digit add-3 lanes; hex passes bits straight through
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (!hex_reg && (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DD_THRESH)) begin
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DD_ADJ;
            end else begin
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        hex_next     = hex_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
            end
            ST_CONV: begin
                // shift one magnitude bit into the digit register
                bcd_next     = {adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next     = mag_reg << 1;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BW'(1)) begin
                    state_next   = ST_STRIP;
                    dig_cnt_next = NDW'(NDIG);
                end
            end
            ST_STRIP: begin
                // drop leading zeros, keep at least one digit
                if ((top_digit == '0) && (dig_cnt_reg > NDW'(1))) begin
                    bcd_next     = bcd_reg << DIGIT_W;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (pop) begin
                    bcd_next = bcd_reg << DIGIT_W;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (start) begin
            state_next   = ST_CONV;
            mag_next     = mag;
            hex_next     = hex;
            bcd_next     = '0;
            bit_cnt_next = BW'(VALUE_WIDTH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        hex_reg     <= hex_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
    end

    assign stat.done  = (state_reg == ST_DONE);
    assign stat.digit = top_digit;
    assign ndig       = dig_cnt_reg;

    a_done_has_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> (dig_cnt_reg != '0))
        else $error("conversion finished with no digits");

    a_conv_to_strip: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && bit_cnt_reg == BW'(1) && !start) |=>
        (state_reg == ST_STRIP))
        else $error("last conversion bit did not move to zero strip");

endmodule

@@ src/itf_emit.sv @@
module itf_emit #(
    parameter int VALUE_WIDTH = itf_pkg::VALUE_WIDTH_DEF,
    localparam int NDIG = itf_pkg::ndigits(VALUE_WIDTH),
    localparam int NDW  = $clog2(NDIG + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  itf_pkg::fmt_t                 fmt,
    input  itf_pkg::conv_stat_t           stat,
    input  logic [NDW-1:0]                ndig,
    output logic                          pop,
    output logic                          finish,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [itf_pkg::CHAR_W-1:0]    m_ascii_char,
    output logic                          m_last
);
    import itf_pkg::*;

    localparam int CMP_W = ((PAD_W > NDW) ? PAD_W : NDW) + 1;

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_WAIT = 3'd1;
    localparam logic [2:0] E_SIGN = 3'd2;
    localparam logic [2:0] E_PAD  = 3'd3;
    localparam logic [2:0] E_DIG  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [PAD_W-1:0]  pad_cnt_reg, pad_cnt_next;
    logic [NDW-1:0]    dig_cnt_reg, dig_cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic              load;
    logic [CMP_W-1:0]  pad_ext, nd_ext, pad_diff;
    logic [PAD_W-1:0]  pad_left;

    assign load     = !m_valid_reg || m_ready;
    assign pad_ext  = CMP_W'(fmt.pad);
    assign nd_ext   = CMP_W'(ndig);
    assign pad_diff = (pad_ext > nd_ext) ? (pad_ext - nd_ext) : '0;
    assign pad_left = pad_diff[PAD_W-1:0];

    always_comb begin
        state_next   = state_reg;
        pad_cnt_next = pad_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        char_next    = char_reg;
        last_next    = last_reg;
        pop          = 1'b0;
        finish       = 1'b0;
        case (state_reg)
            E_IDLE: begin
                if (start) begin
                    state_next = E_WAIT;
                end
            end
            E_WAIT: begin
                if (stat.done) begin
                    pad_cnt_next = pad_left;
                    dig_cnt_next = ndig;
                    if (fmt.negative) begin
                        state_next = E_SIGN;
                    end else if (pad_left != '0) begin
                        state_next = E_PAD;
                    end else begin
                        state_next = E_DIG;
                    end
                end
            end
            E_SIGN: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    char_next    = CHAR_MINUS;
                    last_next    = 1'b0;
                    state_next   = (pad_cnt_reg != '0) ? E_PAD : E_DIG;
                end
            end
            E_PAD: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    char_next    = fmt.zero_pad ? CHAR_ZERO : CHAR_SPACE;
                    last_next    = 1'b0;
                    pad_cnt_next = pad_cnt_reg - 1'b1;
                    if (pad_cnt_reg == PAD_W'(1)) begin
                        state_next = E_DIG;
                    end
                end
            end
            E_DIG: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    char_next    = digit_char(stat.digit, fmt.upper);
                    last_next    = (dig_cnt_reg == NDW'(1));
                    pop          = 1'b1;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == NDW'(1)) begin
                        finish     = 1'b1;
                        state_next = E_IDLE;
                    end
                end
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pad_cnt_reg <= pad_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_ascii_char = char_reg;
    assign m_last       = last_reg;

    a_finish_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> (m_valid && m_last))
        else $error("final digit beat not flagged last");

    a_pop_needs_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> stat.done)
        else $error("digit taken before conversion finished");

    a_sign_only_negative: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == E_SIGN) |-> fmt.negative)
        else $error("sign emitted for non-negative operand");

endmodule

@@ src/integer_to_ascii_formatter.sv @@
// Conversion is bit-serial, one magnitude bit per cycle into the digit shift
// register, followed by a leading-zero strip; then one character per cycle
// while the sink is ready. A new number is accepted only after the last digit
// of the previous one has been loaded into the output register (s_ready is
// low while busy); NDIG is 20 at 64 bits.
// Reset (aresetn, synchronous, active low) clears control state only.
module integer_to_ascii_formatter #(
    parameter int VALUE_WIDTH = itf_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_PAD     = itf_pkg::MAX_PAD_DEF,
    localparam int NDIG = itf_pkg::ndigits(VALUE_WIDTH),
    localparam int NDW  = $clog2(NDIG + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [itf_pkg::VALUE_PORT_W-1:0] s_value,
    input  logic                             s_is_signed,
    input  logic                             s_base_hex,
    input  logic                             s_hex_upper,
    input  logic [itf_pkg::PAD_W-1:0]        s_pad_width,
    input  logic                             s_zero_pad,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [itf_pkg::CHAR_W-1:0]       m_ascii_char,
    output logic                             m_last
);
    import itf_pkg::*;

    logic                   busy_reg, busy_next;
    fmt_t                   fmt_reg, fmt_next;
    logic                   accept;
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   negative;
    logic [PAD_W-1:0]       pad_sat;
    conv_stat_t             stat;
    logic [NDW-1:0]         ndig;
    logic                   pop;
    logic                   finish;

    assign s_ready  = !busy_reg;
    assign accept   = s_valid && s_ready;
    assign raw      = s_value[VALUE_WIDTH-1:0];
    assign negative = s_is_signed && raw[VALUE_WIDTH-1];
    assign mag      = negative ? ('0 - raw) : raw;
    assign pad_sat  = (s_pad_width > PAD_W'(MAX_PAD)) ? PAD_W'(MAX_PAD) : s_pad_width;

    always_comb begin
        busy_next = busy_reg;
        fmt_next  = fmt_reg;
        if (finish) begin
            busy_next = 1'b0;
        end
        if (accept) begin
            busy_next         = 1'b1;
            fmt_next.negative = negative;
            fmt_next.upper    = s_hex_upper;
            fmt_next.zero_pad = s_zero_pad;
            fmt_next.pad      = pad_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        fmt_reg <= fmt_next;
    end

    itf_conv #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .hex     (s_base_hex),
        .mag     (mag),
        .pop     (pop),
        .stat    (stat),
        .ndig    (ndig)
    );

    itf_emit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (accept),
        .fmt          (fmt_reg),
        .stat         (stat),
        .ndig         (ndig),
        .pop          (pop),
        .finish       (finish),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ascii_char (m_ascii_char),
        .m_last       (m_last)
    );

endmodule

@@ bench/tb.sv @@
module tb;
    import itf_pkg::*;

    localparam int VALUE_W     = 64;
    localparam int PAD_LIMIT   = 62;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 1500;
    localparam int DRAIN_WAIT  = 200;
    localparam logic [VALUE_W-1:0] TEN = 64'd10;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_beat_t;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC
    } rx_mode_t;

    logic                aclk         = 1'b0;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [VALUE_W-1:0]  s_value      = '0;
    logic                s_is_signed  = 1'b0;
    logic                s_base_hex   = 1'b0;
    logic                s_hex_upper  = 1'b0;
    logic [PAD_W-1:0]    s_pad_width  = '0;
    logic                s_zero_pad   = 1'b0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [CHAR_W-1:0]   m_ascii_char;
    logic                m_last;

    char_beat_t expected_chars[$];
    char_beat_t head_char;
    int         errors      = 0;
    int         cycle_count = 0;

    // sender pacing, owned by the stimulus process
    bit         gaps_on    = 1'b0;
    int         burst_left = 0;

    // receiver pacing
    rx_mode_t   rx_mode   = RX_ALWAYS;
    int         hold_req  = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         rx_phase  = 0;

    integer_to_ascii_formatter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_is_signed (s_is_signed),
        .s_base_hex  (s_base_hex),
        .s_hex_upper (s_hex_upper),
        .s_pad_width (s_pad_width),
        .s_zero_pad  (s_zero_pad),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_ascii_char(m_ascii_char),
        .m_last      (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d chars still expected", $time, expected_chars.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void push_char(input logic [CHAR_W-1:0] ch, input logic last);
        char_beat_t b;
        b.ch   = ch;
        b.last = last;
        expected_chars.push_back(b);
    endfunction

    // Expected character stream for one number: sign, pad, digits.
    function automatic void format_number(input logic [VALUE_W-1:0] value,
                                          input logic is_signed,
                                          input logic base_hex,
                                          input logic hex_upper,
                                          input logic [PAD_W-1:0] pad_width,
                                          input logic zero_pad);
        logic [VALUE_W-1:0] mag;
        logic               negative;
        logic [CHAR_W-1:0]  digits[VALUE_W];
        logic [CHAR_W-1:0]  pad_ch;
        logic [3:0]         d;
        int                 nd;
        int                 pad;
        int                 total;
        int                 k;
        negative = is_signed & value[VALUE_W-1];
        mag      = negative ? (~value + 1'b1) : value;
        pad_ch   = zero_pad ? CHAR_ZERO : CHAR_SPACE;
        nd       = 0;
        // collect least significant digit first
        do begin
            if (base_hex) begin
                d   = mag[3:0];
                mag = mag >> 4;
            end else begin
                d   = 4'(mag % TEN);
                mag = mag / TEN;
            end
            if (d < DEC_RADIX) begin
                digits[nd] = CHAR_ZERO + CHAR_W'(d);
            end else begin
                digits[nd] = (hex_upper ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(d - DEC_RADIX);
            end
            nd++;
        end while (mag != 0);
        pad   = (int'(pad_width) > PAD_LIMIT) ? PAD_LIMIT : int'(pad_width);
        total = (negative ? 1 : 0) + ((pad > nd) ? pad : nd);
        k     = 0;
        if (negative) begin
            push_char(CHAR_MINUS, k == total - 1);
            k++;
        end
        for (int i = nd; i < pad; i++) begin
            push_char(pad_ch, k == total - 1);
            k++;
        end
        for (int i = nd - 1; i >= 0; i--) begin
            push_char(digits[i], k == total - 1);
            k++;
        end
    endfunction

    // Offer one number; return in the step where it was accepted.
    task automatic send_number(input logic [VALUE_W-1:0] value,
                               input logic is_signed,
                               input logic base_hex,
                               input logic hex_upper,
                               input logic [PAD_W-1:0] pad_width,
                               input logic zero_pad);
        int gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap     = $urandom_range(1, 12);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
                burst_left = $urandom_range(1, 8);
            end
            burst_left--;
        end
        s_valid      <= 1'b1;
        s_value      <= value;
        s_is_signed  <= is_signed;
        s_base_hex   <= base_hex;
        s_hex_upper  <= hex_upper;
        s_pad_width  <= pad_width;
        s_zero_pad   <= zero_pad;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        format_number(value, is_signed, base_hex, hex_upper, pad_width, zero_pad);
    endtask

    // Receiver: long hold on request, otherwise the current stall pattern.
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 1;
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: begin
                    m_ready <= 1'b1;
                end
                RX_RANDOM: begin
                    m_ready <= ($urandom_range(0, 2) != 0);
                end
                default: begin
                    m_ready <= ((rx_phase % 7) >= 3);
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected beat: expected none, actual char=%h last=%b",
                         $time, m_ascii_char, m_last);
                errors++;
            end else begin
                head_char = expected_chars.pop_front();
                if (m_ascii_char !== head_char.ch) begin
                    $display("%0t: ascii_char mismatch: expected %h, actual %h",
                             $time, head_char.ch, m_ascii_char);
                    errors++;
                end
                if (m_last !== head_char.last) begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, head_char.last, m_last);
                    errors++;
                end
            end
        end
    end

    task automatic test_extremes();
        gaps_on = 1'b0;
        rx_mode = RX_ALWAYS;
        send_number(64'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0);
        send_number(64'd0, 1'b1, 1'b1, 1'b1, 6'd0, 1'b1);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1, 6'd0, 1'b0);
        send_number(64'h0123_4567_89AB_CDEF, 1'b0, 1'b1, 1'b0, 6'd0, 1'b0);
        send_number(64'hFEDC_BA98_7654_3210, 1'b0, 1'b1, 1'b1, 6'd0, 1'b0);
        send_number(64'd9, 1'b0, 1'b0, 1'b1, 6'd1, 1'b1);
        send_number(64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0);
    endtask

    task automatic test_padding();
        gaps_on = 1'b0;
        rx_mode = RX_PERIODIC;
        // width above bound saturates
        send_number(64'd7, 1'b0, 1'b0, 1'b0, 6'd63, 1'b1);
        send_number(64'd7, 1'b0, 1'b1, 1'b0, 6'd63, 1'b0);
        send_number(64'd12345, 1'b0, 1'b0, 1'b0, 6'd62, 1'b1);
        // width at or below digit count adds nothing, above it pads the rest
        send_number(64'd12345, 1'b0, 1'b0, 1'b0, 6'd5, 1'b1);
        send_number(64'd12345, 1'b0, 1'b0, 1'b0, 6'd3, 1'b0);
        send_number(64'hABC, 1'b0, 1'b1, 1'b0, 6'd6, 1'b0);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 6'd21, 1'b1);
    endtask

    task automatic test_signed();
        gaps_on = 1'b0;
        rx_mode = RX_RANDOM;
        send_number(64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0);
        send_number(64'h8000_0000_0000_0000, 1'b1, 1'b1, 1'b1, 6'd0, 1'b0);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 6'd4, 1'b1);
        send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0);
        send_number(64'hFFFF_FFFF_FFFF_FF85, 1'b1, 1'b0, 1'b0, 6'd8, 1'b1);
        send_number(64'hFFFF_FFFF_FFFF_FF85, 1'b1, 1'b1, 1'b1, 6'd63, 1'b0);
        send_number(64'd42, 1'b1, 1'b0, 1'b0, 6'd4, 1'b0);
    endtask

    task automatic send_random_number();
        logic [VALUE_W-1:0] value;
        logic [PAD_W-1:0]   pad;
        case ($urandom_range(0, 4))
            0: value = 64'($urandom_range(0, 20));
            1: value = {$urandom, $urandom};
            2: value = 64'($urandom);
            3: value = ($urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : '1)
                       + 64'($urandom_range(0, 8)) - 64'd4;
            default: value = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        if ($urandom_range(0, 3) == 0) begin
            pad = PAD_W'($urandom_range(0, 63));
        end else begin
            pad = PAD_W'($urandom_range(0, 24));
        end
        send_number(value, 1'($urandom), 1'($urandom), 1'($urandom), pad, 1'($urandom));
    endtask

    task automatic test_random();
        int n;
        n = 0;
        gaps_on = 1'b1;
        repeat (120) begin
            // change receiver pacing now and then, with some clean stretches
            if (n % 30 == 0) begin
                case ((n / 30) % 3)
                    0: rx_mode = RX_RANDOM;
                    1: rx_mode = RX_PERIODIC;
                    default: rx_mode = RX_ALWAYS;
                endcase
                gaps_on = ((n / 30) % 4) != 3;
            end
            send_random_number();
            n++;
        end
    endtask

    task automatic test_backpressure();
        gaps_on  = 1'b0;
        rx_mode  = RX_ALWAYS;
        hold_req = hold_req + 1;
        repeat (8) send_random_number();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_padding();
        test_signed();
        test_random();
        test_backpressure();
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

@@ files.f @@
src/itf_pkg.sv
src/itf_conv.sv
src/itf_emit.sv
src/integer_to_ascii_formatter.sv
bench/tb.sv
